/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the packer RTL.
// CEP_ASSERT checks a property with reset masking, CEP_ASSERT_ALWAYS checks it
// at every edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CEP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CEP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CEP_ASSERT(label, clk, rst, prop, msg)
`define CEP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/cep_pkg.sv */
package cep_pkg;

  // register indexes on the config port
  localparam logic [2:0] REG_WIN_LEFT     = 3'd0;
  localparam logic [2:0] REG_WIN_TOP      = 3'd1;
  localparam logic [2:0] REG_WIN_RIGHT    = 3'd2;
  localparam logic [2:0] REG_WIN_BOTTOM   = 3'd3;
  localparam logic [2:0] REG_PANEL_WIDTH  = 3'd4;
  localparam logic [2:0] REG_PANEL_HEIGHT = 3'd5;

  // subpixel rotation patterns
  localparam logic [1:0] PAT_RB = 2'd0;  // upper r|b<<4, lower g|r<<4
  localparam logic [1:0] PAT_GR = 2'd1;  // upper g|r<<4, lower b|g<<4
  localparam logic [1:0] PAT_BG = 2'd2;  // upper b|g<<4, lower r|b<<4

  localparam logic [1:0] LAST_STEP = 2'd2;  // three blocks per six-pixel group

  // reciprocal for divide-by-3 and divide-by-6 on 12-bit values
  localparam int RECIP = 2731;

  typedef struct packed {
    logic [23:0] pix_top_a;
    logic [23:0] pix_top_b;
    logic [23:0] pix_bot_a;
    logic [23:0] pix_bot_b;
  } pix_t;

  typedef struct packed {
    logic [22:0] addr_upper;
    logic [7:0]  byte_upper;
    logic [22:0] addr_lower;
    logic [7:0]  byte_lower;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [11:0] value;
  } cfg_t;

  // window bounds in group columns and half rows
  typedef struct packed {
    logic [9:0]  col_start;
    logic [9:0]  col_end;
    logic [10:0] row_start;
    logic [10:0] row_end;
    logic [1:0]  start_phase;
    logic [11:0] width;
    logic [10:0] half_width;
    logic        empty;
    logic        busy;
    logic        reload;
  } win_t;

  // scan position snapshot for one block
  typedef struct packed {
    logic [10:0] half_row;
    logic [9:0]  group_column;
    logic [1:0]  group_step;
    logic [1:0]  pattern;
    logic        fin;
  } scan_t;

  // floor(x/6) for any 12-bit x
  function automatic logic [9:0] div6(input logic [11:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'(RECIP);
    return p[23:14];
  endfunction

  // x mod 3 for any 11-bit x
  function automatic logic [1:0] mod3(input logic [10:0] x);
    logic [23:0] p;
    logic [9:0]  q;
    logic [10:0] r;
    p = 24'(x) * 24'(RECIP);
    q = p[22:13];
    r = x - 11'({q, 1'b0} + {1'b0, q});
    return r[1:0];
  endfunction

endpackage

/* hw/rtl/cep_stream_if.sv */
// valid/ready channel carrying one item of type T
interface cep_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* hw/rtl/cep_window.sv */
`include "assert_macros.svh"

// Config registers and registered window bounds.
module cep_window (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  input  cep_pkg::cfg_t wr_data,
  output cep_pkg::win_t win
);

  logic [11:0] win_left, win_top, win_right, win_bottom, panel_width, panel_height;
  logic [1:0]  settle;
  logic [1:0]  settle_next;
  logic        wr_hit;

  logic [9:0]  col_start, col_end, col_lim;
  logic [10:0] col_end_raw;
  logic [10:0] row_start, row_lim, row_end;
  logic [11:0] row_end_raw;
  logic [1:0]  start_phase;
  logic        empty;

  // register file, out-of-range indexes ignored
  always_comb begin
    unique case (wr_data.index)
      cep_pkg::REG_WIN_LEFT, cep_pkg::REG_WIN_TOP, cep_pkg::REG_WIN_RIGHT,
      cep_pkg::REG_WIN_BOTTOM, cep_pkg::REG_PANEL_WIDTH,
      cep_pkg::REG_PANEL_HEIGHT: wr_hit = wr_valid;
      default: wr_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left     <= '0;
      win_top      <= '0;
      win_right    <= '0;
      win_bottom   <= '0;
      panel_width  <= '0;
      panel_height <= '0;
    end else if (wr_hit) begin
      unique case (wr_data.index)
        cep_pkg::REG_WIN_LEFT:     win_left     <= wr_data.value;
        cep_pkg::REG_WIN_TOP:      win_top      <= wr_data.value;
        cep_pkg::REG_WIN_RIGHT:    win_right    <= wr_data.value;
        cep_pkg::REG_WIN_BOTTOM:   win_bottom   <= wr_data.value;
        cep_pkg::REG_PANEL_WIDTH:  panel_width  <= wr_data.value;
        cep_pkg::REG_PANEL_HEIGHT: panel_height <= wr_data.value;
        default: ;
      endcase
    end
  end

  // settle: a write updates the config registers, then the registered bounds, then the scan position reloads
  always_comb begin
    if (wr_hit) begin
      settle_next = 2'd2;
    end else if (settle != 2'd0) begin
      settle_next = settle - 2'd1;
    end else begin
      settle_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= '0;
    end else begin
      settle <= settle_next;
    end
  end

  // bound arithmetic
  always_comb begin
    col_start   = cep_pkg::div6(win_left);
    col_end_raw = {1'b0, cep_pkg::div6(win_right)} + 11'd1;
    col_lim     = cep_pkg::div6(panel_width);
    col_end     = (col_end_raw < {1'b0, col_lim}) ? col_end_raw[9:0] : col_lim;
    row_start   = win_top[11:1];
    row_end_raw = {1'b0, win_bottom[11:1]} + 12'd1;
    row_lim     = panel_height[11:1];
    row_end     = (row_end_raw < {1'b0, row_lim}) ? row_end_raw[10:0] : row_lim;
    start_phase = cep_pkg::mod3(row_start);
    empty       = (col_start >= col_end) || (row_start >= row_end);
  end

  // busy and reload track the settle counter
  always_ff @(posedge clk) begin
    if (rst) begin
      win.col_start   <= '0;
      win.col_end     <= '0;
      win.row_start   <= '0;
      win.row_end     <= '0;
      win.start_phase <= '0;
      win.width       <= '0;
      win.half_width  <= '0;
      win.empty       <= 1'b1;
      win.busy        <= 1'b0;
      win.reload      <= 1'b0;
    end else begin
      win.col_start   <= col_start;
      win.col_end     <= col_end;
      win.row_start   <= row_start;
      win.row_end     <= row_end;
      win.start_phase <= start_phase;
      win.width       <= panel_width;
      win.half_width  <= panel_width[11:1];
      win.empty       <= empty;
      win.busy        <= (settle_next != 2'd0);
      win.reload      <= (settle_next == 2'd1);
    end
  end

  `CEP_ASSERT(a_write_holds_off, clk, rst, wr_hit |=> win.busy, "write did not stall input")
  `CEP_ASSERT(a_settle_range, clk, rst, settle != 2'd3, "settle counter out of range")

endmodule

/* hw/rtl/cep_scan.sv */
`include "assert_macros.svh"

// Raster position over the window: step, group column, half row, row phase.
module cep_scan (
  input  logic           clk,
  input  logic           rst,
  input  cep_pkg::win_t  win,
  input  logic           advance,
  output cep_pkg::scan_t pos
);

  logic [9:0]  group_column;
  logic [1:0]  group_step;
  logic [10:0] half_row;
  logic [1:0]  row_phase;

  logic [10:0] col_inc;
  logic [11:0] row_inc;
  logic        col_wrap;
  logic        row_wrap;

  assign col_inc  = {1'b0, group_column} + 11'd1;
  assign row_inc  = {1'b0, half_row} + 12'd1;
  assign col_wrap = (col_inc >= {1'b0, win.col_end});
  assign row_wrap = (row_inc >= {1'b0, win.row_end});

  // position snapshot; pattern = (step - phase) mod 3, both in 0..2
  always_comb begin
    pos.half_row     = half_row;
    pos.group_column = group_column;
    pos.group_step   = group_step;
    pos.fin          = (group_step == cep_pkg::LAST_STEP) && col_wrap && row_wrap;
    if (group_step >= row_phase) begin
      pos.pattern = group_step - row_phase;
    end else begin
      pos.pattern = group_step + 2'd3 - row_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_column <= '0;
      group_step   <= '0;
      half_row     <= '0;
      row_phase    <= '0;
    end else if (win.reload || (advance && pos.fin)) begin
      group_column <= win.col_start;
      group_step   <= '0;
      half_row     <= win.row_start;
      row_phase    <= win.start_phase;
    end else if (advance) begin
      if (group_step != cep_pkg::LAST_STEP) begin
        group_step <= group_step + 2'd1;
      end else begin
        group_step <= '0;
        if (!col_wrap) begin
          group_column <= col_inc[9:0];
        end else begin
          group_column <= win.col_start;
          half_row     <= row_inc[10:0];
          row_phase    <= (row_phase == 2'd2) ? 2'd0 : row_phase + 2'd1;
        end
      end
    end
  end

  `CEP_ASSERT(a_step_range, clk, rst, (group_step != 2'd3) && (row_phase != 2'd3),
              "step or phase out of range")
  `CEP_ASSERT(a_inside_window, clk, rst,
              (!win.busy && !win.empty) |->
              (group_column < win.col_end) && (half_row < win.row_end),
              "scan position left the window")

endmodule

/* hw/rtl/cep_pack.sv */
// Box average of a 2x2 block, nibble packing and destination addresses.
module cep_pack (
  input  cep_pkg::pix_t  pix,
  input  cep_pkg::scan_t pos,
  input  cep_pkg::win_t  win,
  output cep_pkg::res_t  res
);

  logic [5:0]  sum_r, sum_g, sum_b;
  logic [3:0]  r, g, b;
  logic [22:0] row_base;
  logic [11:0] col_off;
  logic [22:0] addr;

  // per-channel sum of the four high nibbles
  always_comb begin
    sum_r = 6'(pix.pix_top_a[7:4]) + 6'(pix.pix_top_b[7:4])
          + 6'(pix.pix_bot_a[7:4]) + 6'(pix.pix_bot_b[7:4]);
    sum_g = 6'(pix.pix_top_a[15:12]) + 6'(pix.pix_top_b[15:12])
          + 6'(pix.pix_bot_a[15:12]) + 6'(pix.pix_bot_b[15:12]);
    sum_b = 6'(pix.pix_top_a[23:20]) + 6'(pix.pix_top_b[23:20])
          + 6'(pix.pix_bot_a[23:20]) + 6'(pix.pix_bot_b[23:20]);
    r = sum_r[5:2];
    g = sum_g[5:2];
    b = sum_b[5:2];
  end

  // rotating subpixel pattern
  always_comb begin
    unique case (pos.pattern)
      cep_pkg::PAT_RB: begin
        res.byte_upper = {b, r};
        res.byte_lower = {r, g};
      end
      cep_pkg::PAT_GR: begin
        res.byte_upper = {r, g};
        res.byte_lower = {g, b};
      end
      default: begin
        res.byte_upper = {g, b};
        res.byte_lower = {b, r};
      end
    endcase
  end

  // half_row * stride + column*3 + step, 23-bit wrap
  always_comb begin
    row_base = 23'(pos.half_row) * 23'(win.width);
    col_off  = {2'b0, pos.group_column} + {1'b0, pos.group_column, 1'b0}
             + 12'(pos.group_step);
    addr     = row_base + 23'(col_off);
  end

  assign res.addr_upper = addr;
  assign res.addr_lower = addr + 23'(win.half_width);
  assign res.last       = pos.fin;

endmodule

/* hw/rtl/color_eink_subpixel_packer.sv */
// An accepted item passes the input register, then the result register, and
// may wait in either while res.ready is low. Throughput: one 2x2 block per
// cycle while res.ready holds and no register write is settling, through the
// input register, the pack/address logic with its single stride multiplier,
// and the result register. A register write stalls input while the window
// bounds settle. Reset (rst, synchronous): config and valid registers clear,
// the window reads empty, and items are taken and dropped until configured.
`include "assert_macros.svh"

module color_eink_subpixel_packer (
  input  logic         clk,
  input  logic         rst,
  cep_stream_if.sink   pix,
  cep_stream_if.source res,
  cep_stream_if.sink   cfg
);

  cep_pkg::win_t  win;
  cep_pkg::scan_t pos;
  cep_pkg::pix_t  s1_pix;
  cep_pkg::scan_t s1_pos;
  cep_pkg::res_t  packed_res;
  cep_pkg::res_t  out_data;
  logic           s1_valid;
  logic           out_valid;
  logic           out_free;
  logic           s1_adv;
  logic           accept;
  logic           keep;

  assign cfg.ready = 1'b1;

  cep_window u_window (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_data  (cfg.data),
    .win      (win)
  );

  // handshake and stage control
  assign out_free  = !out_valid || res.ready;
  assign s1_adv    = s1_valid && out_free;
  assign pix.ready = !win.busy && (!s1_valid || out_free);
  assign accept    = pix.valid && pix.ready;
  assign keep      = accept && !win.empty;

  cep_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .win     (win),
    .advance (keep),
    .pos     (pos)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (keep) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      s1_pix <= pix.data;
      s1_pos <= pos;
    end
  end

  cep_pack u_pack (
    .pix (s1_pix),
    .pos (s1_pos),
    .win (win),
    .res (packed_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= packed_res;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_data;

  `CEP_ASSERT(a_kept_item_staged, clk, rst, keep |=> s1_valid, "kept item not staged")
  `CEP_ASSERT(a_drop_when_empty, clk, rst, (accept && win.empty) |=> !(s1_valid && !$past(s1_valid)),
              "item staged while window empty")

endmodule
